/* hdl/adsr_pkg.sv */
// Shared types, codes and reset constants for the ADSR envelope generator.
// Used by adsr_alu and adsr_envelope_generator; depends on nothing else.

package adsr_pkg;

    // Level format: unsigned Q2.22.
    localparam int LEVEL_BITS = 24;
    localparam int ALU_W      = LEVEL_BITS + 1;
    localparam int CNT_W      = $clog2(LEVEL_BITS);

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [ALU_W-1:0]      alu_word_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [2:0]            op_t;
    typedef logic [2:0]            phase_t;
    typedef logic [2:0]            cfg_idx_t;

    // Command codes carried by the op field.
    localparam op_t OP_TICK       = 3'd0;
    localparam op_t OP_KEY_ON     = 3'd1;
    localparam op_t OP_KEY_OFF    = 3'd2;
    localparam op_t OP_SET_TARGET = 3'd3;
    localparam op_t OP_SET_VALUE  = 3'd4;
    localparam op_t OP_SET_ATTACK = 3'd5;

    // Envelope phase codes.
    localparam phase_t PH_IDLE    = 3'd0;
    localparam phase_t PH_ATTACK  = 3'd1;
    localparam phase_t PH_DECAY   = 3'd2;
    localparam phase_t PH_SUSTAIN = 3'd3;
    localparam phase_t PH_RELEASE = 3'd4;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_ATTACK_RATE     = 3'd0;
    localparam cfg_idx_t CFG_DECAY_RATE      = 3'd1;
    localparam cfg_idx_t CFG_RELEASE_RATE    = 3'd2;
    localparam cfg_idx_t CFG_SUSTAIN_LEVEL   = 3'd3;
    localparam cfg_idx_t CFG_RELEASE_SAMPLES = 3'd4;

    localparam level_t LVL_ONE       = level_t'(1) << (LEVEL_BITS - 2);
    localparam level_t LVL_MAX       = '1;
    localparam level_t ATTACK_RESET  = level_t'(4194);
    localparam level_t DECAY_RESET   = level_t'(4194);
    localparam level_t RELEASE_RESET = level_t'(20972);
    localparam level_t SUSTAIN_RESET = LVL_ONE >> 1;
    localparam cnt_t   DIV_LAST      = cnt_t'(LEVEL_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    // Request to and response from the shared add/subtract unit.
    typedef struct packed {
        logic      sub;
        alu_word_t a;
        alu_word_t b;
    } alu_req_t;

    typedef struct packed {
        alu_word_t res;
        logic      carry;
    } alu_rsp_t;

endpackage

/* hdl/adsr_envelope_generator.sv */
// Top level of the linear ADSR envelope generator: sequencer, state and result register.
// Depends on adsr_pkg and instantiates the shared adder adsr_alu.

// Usage:
// Each input transfer on (in_valid, in_ready) carries one command: op selects a sample
// tick, key on, key off, set target, set value or set attack target, and level is the
// operand of the three set commands. Every command yields exactly one output transfer
// on (out_valid, out_ready) with the envelope level and phase after the command.
// All arithmetic runs through one 25-bit add/subtract unit under a small sequencer,
// so the block takes one command at a time. After a command is accepted it runs the
// execute step (a tick in decay is the longest), then loads the result register in
// its final step; the next command is taken the cycle after that. Key off with a
// nonzero release_samples computes the release step by restoring division, one
// quotient bit per cycle, between the execute step and the final step.
// The result register parts the two channels: a new command is accepted while the
// previous result still waits; only when a second result is ready and the receiver
// still stalls does the sequencer hold in its final step.
// Configuration registers are written through (cfg_we, cfg_index, cfg_data); the user
// must write them only while the block is idle, which the block does not enforce. Reset
// is asynchronous and resets all but the working and result payload registers at once.

module adsr_envelope_generator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  adsr_pkg::op_t         op,
    input  adsr_pkg::level_t      level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output adsr_pkg::level_t      env_level,
    output adsr_pkg::phase_t      phase,
    input  logic                  cfg_we,
    input  adsr_pkg::cfg_idx_t    cfg_index,
    input  adsr_pkg::level_t      cfg_data
);
    import adsr_pkg::*;

    // Configuration registers.
    level_t attack_rate_reg, attack_rate_next;
    level_t decay_rate_reg, decay_rate_next;
    level_t release_rate_reg, release_rate_next;
    level_t sustain_level_reg, sustain_level_next;
    level_t release_samples_reg, release_samples_next;

    // Envelope state.
    level_t level_now_reg, level_now_next;
    level_t target_now_reg, target_now_next;
    level_t sustain_now_reg, sustain_now_next;
    level_t release_step_reg, release_step_next;
    phase_t phase_now_reg, phase_now_next;

    // Sequencer and working registers.
    seq_state_t state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    op_t        op_reg, op_next;
    level_t     operand_reg, operand_next;
    level_t     tmp_reg, tmp_next;
    level_t     dvd_reg, dvd_next;
    logic       down_reg, down_next;

    // Result register.
    logic   out_valid_reg, out_valid_next;
    level_t env_level_reg, env_level_next;
    phase_t phase_out_reg, phase_out_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic     exec_done;
    logic     exec_div;
    logic     out_load;

    adsr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Output and handshake decode.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        out_valid = out_valid_reg;
        env_level = env_level_reg;
        phase     = phase_out_reg;
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_div)
                begin
                    state_next = ST_DIV;
                end
                else if (exec_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath: every arithmetic step goes through the shared unit.
    always_comb
    begin
        attack_rate_next     = attack_rate_reg;
        decay_rate_next      = decay_rate_reg;
        release_rate_next    = release_rate_reg;
        sustain_level_next   = sustain_level_reg;
        release_samples_next = release_samples_reg;
        level_now_next       = level_now_reg;
        target_now_next      = target_now_reg;
        sustain_now_next     = sustain_now_reg;
        release_step_next    = release_step_reg;
        phase_now_next       = phase_now_reg;
        cnt_next             = cnt_reg;
        op_next              = op_reg;
        operand_next         = operand_reg;
        tmp_next             = tmp_reg;
        dvd_next             = dvd_reg;
        down_next            = down_reg;
        out_valid_next       = out_valid_reg;
        env_level_next       = env_level_reg;
        phase_out_next       = phase_out_reg;
        exec_done            = 1'b0;
        exec_div             = 1'b0;
        alu_req.sub          = 1'b0;
        alu_req.a            = {1'b0, level_now_reg};
        alu_req.b            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    operand_next = level;
                    cnt_next     = '0;
                end
            end
            ST_EXEC:
            begin
                cnt_next = cnt_reg + cnt_t'(1);
                case (op_reg)
                    OP_TICK:
                    begin
                        case (phase_now_reg)
                            PH_ATTACK:
                            begin
                                if (cnt_reg == cnt_t'(0))
                                begin
                                    alu_req.b = {1'b0, attack_rate_reg};
                                    // Saturate at the top of the range.
                                    tmp_next  = alu_rsp.res[LEVEL_BITS] ? LVL_MAX
                                                : alu_rsp.res[LEVEL_BITS-1:0];
                                end
                                else
                                begin
                                    alu_req.sub = 1'b1;
                                    alu_req.a   = {1'b0, tmp_reg};
                                    alu_req.b   = {1'b0, target_now_reg};
                                    exec_done   = 1'b1;
                                    if (alu_rsp.carry)
                                    begin
                                        level_now_next  = target_now_reg;
                                        target_now_next = sustain_now_reg;
                                        phase_now_next  = PH_DECAY;
                                    end
                                    else
                                    begin
                                        level_now_next = tmp_reg;
                                    end
                                end
                            end
                            PH_DECAY:
                            begin
                                case (cnt_reg)
                                    cnt_t'(0):
                                    begin
                                        // Distance to sustain, assuming the level is above it.
                                        alu_req.sub = 1'b1;
                                        alu_req.b   = {1'b0, sustain_now_reg};
                                        tmp_next    = alu_rsp.res[LEVEL_BITS-1:0];
                                        down_next   = alu_rsp.carry;
                                    end
                                    cnt_t'(1):
                                    begin
                                        // Level below sustain: take the distance the other way.
                                        alu_req.sub = 1'b1;
                                        alu_req.a   = {1'b0, sustain_now_reg};
                                        alu_req.b   = {1'b0, level_now_reg};
                                        if (!down_reg)
                                        begin
                                            tmp_next = alu_rsp.res[LEVEL_BITS-1:0];
                                        end
                                    end
                                    cnt_t'(2):
                                    begin
                                        alu_req.sub = 1'b1;
                                        alu_req.a   = {1'b0, decay_rate_reg};
                                        alu_req.b   = {1'b0, tmp_reg};
                                        if (alu_rsp.carry)
                                        begin
                                            level_now_next = sustain_now_reg;
                                            phase_now_next = PH_SUSTAIN;
                                            exec_done      = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        alu_req.sub    = down_reg;
                                        alu_req.b      = {1'b0, decay_rate_reg};
                                        level_now_next = alu_rsp.res[LEVEL_BITS-1:0];
                                        exec_done      = 1'b1;
                                    end
                                endcase
                            end
                            PH_RELEASE:
                            begin
                                if (cnt_reg == cnt_t'(0))
                                begin
                                    alu_req.sub = 1'b1;
                                    alu_req.a   = {1'b0, release_step_reg};
                                    alu_req.b   = {1'b0, level_now_reg};
                                    if (alu_rsp.carry)
                                    begin
                                        level_now_next = '0;
                                        phase_now_next = PH_IDLE;
                                        exec_done      = 1'b1;
                                    end
                                end
                                else
                                begin
                                    alu_req.sub    = 1'b1;
                                    alu_req.b      = {1'b0, release_step_reg};
                                    level_now_next = alu_rsp.res[LEVEL_BITS-1:0];
                                    exec_done      = 1'b1;
                                end
                            end
                            default:
                            begin
                                exec_done = 1'b1;
                            end
                        endcase
                    end
                    OP_KEY_ON:
                    begin
                        if (target_now_reg == '0)
                        begin
                            target_now_next = LVL_ONE;
                        end
                        phase_now_next = PH_ATTACK;
                        exec_done      = 1'b1;
                    end
                    OP_KEY_OFF:
                    begin
                        target_now_next = '0;
                        phase_now_next  = PH_RELEASE;
                        if (release_samples_reg != '0)
                        begin
                            // Start the division level_now / release_samples.
                            dvd_next = level_now_reg;
                            tmp_next = '0;
                            cnt_next = '0;
                            exec_div = 1'b1;
                        end
                        else
                        begin
                            release_step_next = release_rate_reg;
                            exec_done         = 1'b1;
                        end
                    end
                    OP_SET_TARGET:
                    begin
                        alu_req.sub      = 1'b1;
                        alu_req.b        = {1'b0, operand_reg};
                        target_now_next  = operand_reg;
                        sustain_now_next = operand_reg;
                        exec_done        = 1'b1;
                        if (!alu_rsp.carry)
                        begin
                            phase_now_next = PH_ATTACK;
                        end
                        else if (alu_rsp.res[LEVEL_BITS-1:0] != '0)
                        begin
                            phase_now_next = PH_DECAY;
                        end
                    end
                    OP_SET_VALUE:
                    begin
                        phase_now_next   = PH_SUSTAIN;
                        target_now_next  = operand_reg;
                        level_now_next   = operand_reg;
                        sustain_now_next = operand_reg;
                        exec_done        = 1'b1;
                    end
                    OP_SET_ATTACK:
                    begin
                        target_now_next = operand_reg;
                        exec_done       = 1'b1;
                    end
                    default:
                    begin
                        exec_done = 1'b1;
                    end
                endcase
            end
            ST_DIV:
            begin
                // Restoring division: shift in one dividend bit, trial subtract.
                alu_req.sub = 1'b1;
                alu_req.a   = {tmp_reg, dvd_reg[LEVEL_BITS-1]};
                alu_req.b   = {1'b0, release_samples_reg};
                tmp_next    = alu_rsp.carry ? alu_rsp.res[LEVEL_BITS-1:0]
                              : alu_req.a[LEVEL_BITS-1:0];
                dvd_next    = {dvd_reg[LEVEL_BITS-2:0], alu_rsp.carry};
                cnt_next    = cnt_reg + cnt_t'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    release_step_next = {dvd_reg[LEVEL_BITS-2:0], alu_rsp.carry};
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    env_level_next = level_now_reg;
                    phase_out_next = phase_now_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK_RATE:
                begin
                    attack_rate_next = cfg_data;
                end
                CFG_DECAY_RATE:
                begin
                    decay_rate_next = cfg_data;
                end
                CFG_RELEASE_RATE:
                begin
                    release_rate_next = cfg_data;
                    release_step_next = cfg_data;
                end
                CFG_SUSTAIN_LEVEL:
                begin
                    sustain_level_next = cfg_data;
                    sustain_now_next   = cfg_data;
                end
                CFG_RELEASE_SAMPLES:
                begin
                    release_samples_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_rate_reg     <= ATTACK_RESET;
            decay_rate_reg      <= DECAY_RESET;
            release_rate_reg    <= RELEASE_RESET;
            sustain_level_reg   <= SUSTAIN_RESET;
            release_samples_reg <= '0;
            level_now_reg       <= '0;
            target_now_reg      <= '0;
            sustain_now_reg     <= SUSTAIN_RESET;
            release_step_reg    <= RELEASE_RESET;
            phase_now_reg       <= PH_IDLE;
            state_reg           <= ST_IDLE;
            cnt_reg             <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            attack_rate_reg     <= attack_rate_next;
            decay_rate_reg      <= decay_rate_next;
            release_rate_reg    <= release_rate_next;
            sustain_level_reg   <= sustain_level_next;
            release_samples_reg <= release_samples_next;
            level_now_reg       <= level_now_next;
            target_now_reg      <= target_now_next;
            sustain_now_reg     <= sustain_now_next;
            release_step_reg    <= release_step_next;
            phase_now_reg       <= phase_now_next;
            state_reg           <= state_next;
            cnt_reg             <= cnt_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Working and result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        operand_reg   <= operand_next;
        tmp_reg       <= tmp_next;
        dvd_reg       <= dvd_next;
        down_reg      <= down_next;
        env_level_reg <= env_level_next;
        phase_out_reg <= phase_out_next;
    end

    // The sequencer is busy in the cycle after taking a command.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while the previous one was still in work");

    // The divider only runs with a nonzero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> release_samples_reg != '0)
        else $error("release step division started with a zero divisor");

    // A finished command whose result slot is free shows its result next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && !out_valid_reg |=> out_valid && in_ready)
        else $error("finished command did not produce a result");

endmodule

/* hdl/adsr_alu.sv */
// Shared add/subtract unit of the ADSR envelope generator.
// Depends on adsr_pkg for the request and response structs.

module adsr_alu (
    input  adsr_pkg::alu_req_t req,
    output adsr_pkg::alu_rsp_t rsp
);
    import adsr_pkg::*;

    logic [ALU_W:0] sum;

    // For a subtract the carry out is set exactly when a >= b.
    // For an add it is the overflow beyond the operand width.
    always_comb
    begin
        sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
              + {{ALU_W{1'b0}}, req.sub};
        rsp.res   = sum[ALU_W-1:0];
        rsp.carry = sum[ALU_W];
    end

endmodule
